// ===== sv/assert_macros.svh =====
// Concurrent assertion wrappers for the rank unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define RBSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RBSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RBSP_ASSERT(lbl, clk, rstn, prop, msg)
`define RBSP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/rbsp_pkg.sv =====
package rbsp_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VAL_W      = 32;
  localparam int RANK_W     = 6;
  localparam int IDX_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int NUM_BANKS  = 2;
  localparam int ADDR_W     = IDX_W + $clog2(NUM_BANKS);
  localparam int RAM_DEPTH  = NUM_BANKS * MAX_ITEMS;
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] n;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } jobq_status_t;

endpackage

// ===== sv/rbsp_ram.sv =====
module rbsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/rbsp_front.sv =====
module rbsp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rbsp_pkg::VAL_W-1:0]   in_value,
  input  logic                         in_last,
  input  rbsp_pkg::jobq_status_t       q_status,
  output logic                         busy,
  output logic                         wr_en,
  output logic [rbsp_pkg::ADDR_W-1:0]  wr_addr,
  output logic [rbsp_pkg::VAL_W-1:0]   wr_data,
  output logic                         push,
  output rbsp_pkg::job_t               push_job
);
  import rbsp_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             bank_r, bank_nxt;
  logic             accept;
  logic             room;

  assign accept = start && !q_status.full;
  assign room   = cnt_r < CNT_W'(MAX_ITEMS);
  assign busy   = q_status.full;

  assign wr_en   = accept && room;
  assign wr_addr = {bank_r, cnt_r[IDX_W-1:0]};
  assign wr_data = in_value;

  assign push          = accept && in_last;
  assign push_job.bank = bank_r;
  assign push_job.n    = room ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    bank_nxt = bank_r;
    if (push) begin
      cnt_nxt  = '0;
      bank_nxt = !bank_r;
    end else if (wr_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// ===== sv/rbsp_jobq.sv =====
module rbsp_jobq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rbsp_pkg::job_t         push_job,
  input  logic                   pop,
  output rbsp_pkg::job_t         head,
  output rbsp_pkg::jobq_status_t status
);
  import rbsp_pkg::*;

  job_t                  q_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOBQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOBQ_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign status.valid = count_r != '0;
  assign status.full  = count_r == JOBQ_CNT_W'(JOBQ_DEPTH);
  assign head         = q_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && status.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + JOBQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + JOBQ_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + JOBQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - JOBQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== sv/rbsp_back.sv =====
`include "assert_macros.svh"

module rbsp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rbsp_pkg::jobq_status_t       q_status,
  input  rbsp_pkg::job_t               job,
  output logic                         pop,
  output logic [rbsp_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [rbsp_pkg::VAL_W-1:0]   rd_data,
  output logic                         out_strobe,
  output logic [rbsp_pkg::RANK_W-1:0]  out_rank,
  output logic                         out_final_res
);
  import rbsp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PIVOT = 3'b010,
    S_SWEEP = 3'b100
  } bstate_t;

  bstate_t           state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [RANK_W-1:0] cnt_r, cnt_nxt;
  logic              first_r, first_nxt;
  logic [VAL_W-1:0]  pivot_r;
  logic              out_strobe_r, out_strobe_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic              out_final_r, out_final_nxt;
  logic              lt;
  logic [RANK_W-1:0] cnt_sum;
  logic              is_final;

  assign rd_addr = {job.bank, (state_r == S_PIVOT) ? i_r : j_r[IDX_W-1:0]};

  assign lt       = !first_r && ($signed(rd_data) < $signed(pivot_r));
  assign cnt_sum  = cnt_r + RANK_W'(lt);
  assign is_final = (CNT_W'(i_r) + CNT_W'(1)) == job.n;

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cnt_nxt        = cnt_r;
    first_nxt      = first_r;
    out_strobe_nxt = 1'b0;
    out_rank_nxt   = out_rank_r;
    out_final_nxt  = out_final_r;
    pop            = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_status.valid) begin
          i_nxt     = '0;
          state_nxt = S_PIVOT;
        end
      end
      S_PIVOT: begin
        j_nxt     = '0;
        cnt_nxt   = '0;
        first_nxt = 1'b1;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        first_nxt = 1'b0;
        if (j_r == job.n) begin
          out_strobe_nxt = 1'b1;
          out_rank_nxt   = cnt_sum;
          out_final_nxt  = is_final;
          if (is_final) begin
            pop       = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_PIVOT;
          end
        end else begin
          j_nxt   = j_r + CNT_W'(1);
          cnt_nxt = cnt_sum;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    cnt_r       <= cnt_nxt;
    first_r     <= first_nxt;
    out_rank_r  <= out_rank_nxt;
    out_final_r <= out_final_nxt;
    if (state_r == S_SWEEP && first_r) begin
      pivot_r <= rd_data;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_rank      = out_rank_r;
  assign out_final_res = out_final_r;

  `RBSP_ASSERT(a_job_held, clk, rst_n, (state_r != S_IDLE) |-> q_status.valid, "ranking without a job")
  `RBSP_ASSERT(a_final_pops, clk, rst_n, (out_strobe_r && out_final_r) |-> $past(pop), "final word without pop")
  `RBSP_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_strobe_r, "word out after reset")

endmodule

// ===== sv/rank_by_sorted_position_unit.sv =====
// Rank unit: gives each value of a run the count of smaller (signed) run values.
// Input words come on start/busy: a word (in_value, in_last) is taken at a clock
// edge with start high and busy low, so one word per cycle can be loaded.
// A word with in_last set closes the run; up to 64 values are kept per run and
// further values are dropped, though their in_last still closes the run.
// After a run closes, one result word per kept value appears in load order on
// out_rank/out_final_res, each valid for the single cycle that out_strobe is
// high; out_final_res marks the last. The receiver cannot stall this channel.
// For each kept value of a closed run, the ranking side reads it as the pivot,
// then sweeps all n values of the run, one memory read per cycle on the value
// store, and counts those below the pivot before it gives the result word.
// Runs are queued two deep on two banks of the store: loading of the next
// run goes on while the previous one is ranked, and busy rises only when
// two closed runs wait or are being ranked.
// A synchronous reset (rst_n low) empties the queue and drops any run in
// progress; the value store needs no clearing.
module rank_by_sorted_position_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rbsp_pkg::VAL_W-1:0]   in_value,
  input  logic                         in_last,
  output logic                         out_strobe,
  output logic [rbsp_pkg::RANK_W-1:0]  out_rank,
  output logic                         out_final_res
);
  import rbsp_pkg::*;

  jobq_status_t     q_status;
  job_t             push_job;
  job_t             head;
  logic             push;
  logic             pop;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_data;

  rbsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_value (in_value),
    .in_last  (in_last),
    .q_status (q_status),
    .busy     (busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .push_job (push_job)
  );

  rbsp_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  rbsp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rbsp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .job           (head),
    .pop           (pop),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_strobe    (out_strobe),
    .out_rank      (out_rank),
    .out_final_res (out_final_res)
  );

endmodule

// ===== sim/rank_by_sorted_position_unit_tb.sv =====
module rank_by_sorted_position_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbsp_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [VAL_W-1:0]   in_value;
  logic               in_last;
  logic               out_strobe;
  logic [RANK_W-1:0]  out_rank;
  logic               out_final_res;

  int error_count;
  bit back_to_back;

  // Values of the run being loaded, as the block should hold them.
  logic signed [VAL_W-1:0] run_values [MAX_ITEMS];
  int                      run_len;

  // Ranks still to come, oldest first.
  logic [RANK_W-1:0] pending_ranks [$];
  bit                pending_final [$];

  logic [RANK_W-1:0] want_rank;
  bit                want_final;

  rank_by_sorted_position_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_strobe    (out_strobe),
    .out_rank      (out_rank),
    .out_final_res (out_final_res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Stores the value while there is room; a closing word yields one rank
  // per stored value, in load order.
  function automatic void predict_ranks(logic [VAL_W-1:0] value, bit last_flag);
    int smaller;
    if (run_len < MAX_ITEMS) begin
      run_values[run_len] = value;
      run_len++;
    end
    if (last_flag) begin
      for (int i = 0; i < run_len; i++) begin
        smaller = 0;
        for (int j = 0; j < run_len; j++) begin
          if (run_values[j] < run_values[i]) smaller++;
        end
        pending_ranks.push_back(RANK_W'(smaller));
        pending_final.push_back(i == run_len - 1);
      end
      run_len = 0;
    end
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(int style);
    logic [VAL_W-1:0] corner [8];
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
               32'h0000_0001, 32'h8000_0001, 32'h7fff_fffe, 32'hffff_fffe};
    case (style)
      0: return $urandom;
      1: return VAL_W'($urandom_range(0, 6)) - VAL_W'(3);
      default: return corner[$urandom_range(0, 7)];
    endcase
  endfunction

  task automatic send_word(input logic [VAL_W-1:0] value, input bit last_flag);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= value;
    in_last  <= last_flag;
    do @(posedge clk); while (busy !== 1'b0);
    predict_ranks(value, last_flag);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_run(input logic [VAL_W-1:0] values [$]);
    foreach (values[k]) send_word(values[k], k == values.size() - 1);
  endtask

  task automatic test_single_value();
    send_word(32'h1234_5678, 1'b1);
  endtask

  task automatic test_extremes();
    send_run('{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
               32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff, 32'haaaa_5555});
  endtask

  task automatic test_equal_values();
    send_run('{32'hdead_beef, 32'hdead_beef, 32'hdead_beef, 32'hdead_beef});
  endtask

  task automatic test_ordered_runs();
    back_to_back = 1'b1;
    send_run('{32'hffff_fffd, 32'hffff_fffe, 32'h0000_0000, 32'h0000_0005});
    send_run('{32'h0000_0009, 32'h0000_0002, 32'hffff_ffff, 32'h8000_0000});
    back_to_back = 1'b0;
  endtask

  // Values past the capacity are dropped, the closing one too.
  task automatic test_capacity();
    for (int k = 0; k < MAX_ITEMS + 2; k++) begin
      send_word(pick_value(k % 3), k == MAX_ITEMS + 1);
    end
    wait_for_results();
  endtask

  task automatic test_random_runs();
    int items;
    int run_length;
    int style;
    int sel;
    int large_runs;
    items = 0;
    large_runs = 0;
    while (items < 310) begin
      sel = $urandom_range(0, 99);
      if (sel < 4 && large_runs < 3) begin
        run_length = $urandom_range(MAX_ITEMS, MAX_ITEMS + 6);
        large_runs++;
      end else if (sel < 15) begin
        run_length = $urandom_range(13, 40);
      end else begin
        run_length = $urandom_range(1, 12);
      end
      style = $urandom_range(0, 2);
      back_to_back = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < run_length; k++) begin
        send_word(pick_value(style), k == run_length - 1);
      end
      items += run_length;
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
    back_to_back = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      if (pending_ranks.size() == 0) begin
        $error("unexpected result word: rank %0d, final_res %0b", out_rank, out_final_res);
        error_count++;
      end else begin
        want_rank  = pending_ranks.pop_front();
        want_final = pending_final.pop_front();
        if (out_rank !== want_rank) begin
          $error("rank: expected %0d, got %0d", want_rank, out_rank);
          error_count++;
        end
        if (out_final_res !== want_final) begin
          $error("final_res: expected %0b, got %0b", want_final, out_final_res);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count  = 0;
    back_to_back = 1'b0;
    run_len      = 0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_value <= '0;
    in_last  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_value();
    test_extremes();
    test_equal_values();
    wait_for_results();
    test_ordered_runs();
    test_capacity();
    test_random_runs();

    wait_for_results();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rbsp_pkg.sv
sv/rbsp_ram.sv
sv/rbsp_front.sv
sv/rbsp_jobq.sv
sv/rbsp_back.sv
sv/rank_by_sorted_position_unit.sv
sim/rank_by_sorted_position_unit_tb.sv
